/* sv/acrp_pkg.sv */
// package for the atlas column rectangle packer
// holds payload structs, status codes, opcodes, register indexes and sizes; no dependencies
package acrp_pkg;

  localparam int MAX_NODES_DEF   = 256;
  localparam int MAX_COLUMNS_DEF = 32;
  localparam int COORD_LIMIT_DEF = 1024;

  localparam int CW = 11;  // coordinate width

  localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PAD_MARGIN   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic          opcode;
    logic [10:0]   img_width;
    logic [10:0]   img_height;
  } acrp_in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [9:0]    place_x;
    logic [9:0]    place_y;
  } acrp_out_t;

endpackage

/* sv/acrp_node_store.sv */
// node table memory for the packer: one write port, one registered read port
// depends on acrp_pkg
module acrp_node_store import acrp_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int AW  = $clog2(MAX_NODES),
  localparam int CLW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int DW  = 5 * CW + 1 + CLW
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [MAX_NODES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/atlas_column_rect_packer.sv */
// top level of the atlas column rectangle packer: sequencer, column table, node scan
// depends on acrp_pkg and acrp_node_store
// clear and too-large results strobe in the cycle after accept; an allocation scans every
// node in each column pass until one fits (read state, then check state for each node)
// one item at a time; busy drops in the cycle the result strobes, a new item may start then
// reset (synchronous rst_n): one root node, registers at 1024/1024/1; receiver cannot stall
module atlas_column_rect_packer import acrp_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int COORD_LIMIT = COORD_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  acrp_in_t  in_item,
  output logic      out_strobe,
  output acrp_out_t out_item,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int CLW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int DW  = 5 * CW + 1 + CLW;
  localparam int SW  = 13;  // wide enough for coordinate sums
  // an 11-bit register never exceeds 2047, so a larger limit never clips
  localparam logic [SW-1:0] LIMIT = SW'((COORD_LIMIT > 2047) ? 2047 : COORD_LIMIT);
  // reset atlas size of 1024 after clipping
  localparam logic [CW-1:0] RESET_SIZE = CW'((COORD_LIMIT < 1024) ? COORD_LIMIT : 1024);

  typedef struct packed {
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CW-1:0]  w;
    logic [CW-1:0]  h;
    logic           has_child;
    logic [CW-1:0]  child_bottom;
    logic [CLW-1:0] col;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE, S_COL, S_RD, S_CHK, S_WPAR, S_NEWCOL, S_NEW2
  } state_t;

  state_t state_r;
  logic [10:0] aw_reg_r, ah_reg_r;
  logic [3:0]  margin_r;
  logic [NCW-1:0] node_count_r;
  logic [CCW-1:0] col_count_r;
  logic [CW-1:0]  last_ext_r;
  logic [CW-1:0]  col_right_r [MAX_COLUMNS];
  logic [CCW-1:0] col_idx_r;
  logic [NCW-1:0] node_idx_r;
  logic [SW-1:0]  w_r, h_r;
  logic [CW-1:0]  edge_r;
  logic [CW-1:0]  px_r, py_r;
  node_t          hit_r;
  logic [AW-1:0]  hit_idx_r;
  logic           out_strobe_r;
  acrp_out_t      out_item_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  node_t         wr_node, rd_node;
  logic [DW-1:0] rd_data;

  acrp_node_store #(.MAX_NODES(MAX_NODES), .MAX_COLUMNS(MAX_COLUMNS)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(DW'(wr_node)),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );
  assign rd_node = node_t'(rd_data);

  // limited atlas sizes
  logic [SW-1:0] aw_l, ah_l, aw_raw, ah_raw;
  assign aw_raw = SW'(aw_reg_r);
  assign ah_raw = SW'(ah_reg_r);
  assign aw_l = (aw_raw > LIMIT) ? LIMIT : aw_raw;
  assign ah_l = (ah_raw > LIMIT) ? LIMIT : ah_raw;

  // padded request
  logic [SW-1:0] pw, ph;
  assign pw = SW'(in_item.img_width)  + SW'({margin_r, 1'b0});
  assign ph = SW'(in_item.img_height) + SW'({margin_r, 1'b0});

  // fit check on the node read last cycle
  logic [SW-1:0] n_px, n_py;
  logic          n_fit;
  always_comb begin
    n_px = SW'(rd_node.x) + SW'(rd_node.w);
    if (!rd_node.has_child) begin
      n_py  = SW'(rd_node.y);
      n_fit = (SW'(rd_node.h) >= h_r) && (n_px + w_r <= SW'(edge_r));
    end else begin
      n_py  = SW'(rd_node.child_bottom);
      n_fit = (n_py + h_r <= SW'(rd_node.y) + SW'(rd_node.h)) &&
              (n_px + w_r <= SW'(edge_r));
    end
  end

  logic node_full;
  assign node_full = (node_count_r >= NCW'(MAX_NODES));
  logic [SW-1:0] new_end;
  assign new_end = SW'(last_ext_r) + w_r;

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_count_r[AW-1:0];
    wr_node = '0;
    rd_addr = node_idx_r[AW-1:0];
    if (!rst_n) begin
      // root node written while reset is held
      wr_en     = 1'b1;
      wr_addr   = '0;
      wr_node.h = RESET_SIZE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start && in_item.opcode == OP_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_node.h = ah_l[CW-1:0];
          end
        end
        S_WPAR: begin
          // parent gains a child; the new node was appended in S_CHK
          wr_en   = 1'b1;
          wr_addr = hit_idx_r;
          wr_node = hit_r;
          wr_node.has_child    = 1'b1;
          wr_node.child_bottom = CW'(SW'(py_r) + h_r);
        end
        S_CHK: begin
          if (rd_node.col == col_idx_r[CLW-1:0] && n_fit && !node_full) begin
            wr_en   = 1'b1;
            wr_addr = node_count_r[AW-1:0];
            wr_node.x   = n_px[CW-1:0];
            wr_node.y   = n_py[CW-1:0];
            wr_node.w   = w_r[CW-1:0];
            wr_node.h   = h_r[CW-1:0];
            wr_node.col = col_idx_r[CLW-1:0];
          end
        end
        S_NEWCOL: begin
          wr_en   = 1'b1;
          wr_node.x = last_ext_r;
          wr_node.h = ah_l[CW-1:0];
          wr_node.has_child    = 1'b1;
          wr_node.child_bottom = h_r[CW-1:0];
          wr_node.col = col_count_r[CLW-1:0];
        end
        S_NEW2: begin
          wr_en   = 1'b1;
          wr_node.x = last_ext_r;
          wr_node.w = w_r[CW-1:0];
          wr_node.h = h_r[CW-1:0];
          wr_node.col = col_count_r[CLW-1:0];
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      aw_reg_r     <= 11'd1024;
      ah_reg_r     <= 11'd1024;
      margin_r     <= 4'd1;
      node_count_r <= NCW'(1);
      col_count_r  <= CCW'(1);
      last_ext_r   <= '0;
      col_right_r[0] <= RESET_SIZE;
      out_strobe_r <= 1'b0;
      col_idx_r    <= '0;
      node_idx_r   <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ATLAS_WIDTH:  aw_reg_r <= cfg_data;
          CFG_ATLAS_HEIGHT: ah_reg_r <= cfg_data;
          CFG_PAD_MARGIN:   margin_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            w_r <= pw;
            h_r <= ph;
            col_idx_r  <= '0;
            node_idx_r <= '0;
            edge_r     <= col_right_r[0];
            if (in_item.opcode == OP_CLEAR) begin
              node_count_r   <= NCW'(1);
              col_count_r    <= CCW'(1);
              last_ext_r     <= '0;
              col_right_r[0] <= aw_l[CW-1:0];
              out_strobe_r   <= 1'b1;
              out_item_r     <= '{ST_OK, 10'd0, 10'd0};
            end else if (pw > aw_l || ph > ah_l) begin
              out_strobe_r <= 1'b1;
              out_item_r   <= '{ST_TOO_BIG, 10'd0, 10'd0};
            end else begin
              state_r <= S_COL;
            end
          end
        end
        S_COL: begin
          // start a column pass, or when all are done open a new column or report no room or full
          node_idx_r <= '0;
          if (col_idx_r < col_count_r && col_idx_r < CCW'(MAX_COLUMNS)) begin
            edge_r  <= col_right_r[col_idx_r[CLW-1:0]];
            state_r <= S_RD;
          end else if (new_end > aw_l) begin
            out_strobe_r <= 1'b1;
            out_item_r   <= '{ST_NO_ROOM, 10'd0, 10'd0};
            state_r      <= S_IDLE;
          end else if (col_count_r >= CCW'(MAX_COLUMNS) ||
                       NCW'(node_count_r + NCW'(2)) > NCW'(MAX_NODES) ||
                       node_count_r > NCW'(MAX_NODES - 2)) begin
            out_strobe_r <= 1'b1;
            out_item_r   <= '{ST_FULL, 10'd0, 10'd0};
            state_r      <= S_IDLE;
          end else begin
            col_right_r[col_count_r[CLW-1:0] - CLW'(1)] <= last_ext_r;
            state_r <= S_NEWCOL;
          end
        end
        S_RD: begin
          // node read is in flight; past the last node the pass ends and the next column starts
          if (node_idx_r < node_count_r) begin
            state_r <= S_CHK;
          end else begin
            col_idx_r <= col_idx_r + CCW'(1);
            state_r   <= S_COL;
          end
        end
        S_CHK: begin
          if (rd_node.col == col_idx_r[CLW-1:0] && n_fit) begin
            if (node_full) begin
              out_strobe_r <= 1'b1;
              out_item_r   <= '{ST_FULL, 10'd0, 10'd0};
              state_r      <= S_IDLE;
            end else begin
              hit_r     <= rd_node;
              hit_idx_r <= node_idx_r[AW-1:0];
              px_r      <= n_px[CW-1:0];
              py_r      <= n_py[CW-1:0];
              node_count_r <= node_count_r + NCW'(1);
              if (col_idx_r + CCW'(1) == col_count_r &&
                  n_px + w_r > SW'(last_ext_r)) begin
                last_ext_r <= CW'(n_px + w_r);
              end
              state_r <= S_WPAR;
            end
          end else begin
            node_idx_r <= node_idx_r + NCW'(1);
            state_r    <= S_RD;
          end
        end
        S_WPAR: begin
          out_strobe_r <= 1'b1;
          out_item_r   <= '{ST_OK, 10'(SW'(px_r) + SW'(margin_r)),
                            10'(SW'(py_r) + SW'(margin_r))};
          state_r      <= S_IDLE;
        end
        S_NEWCOL: begin
          col_right_r[col_count_r[CLW-1:0]] <= aw_l[CW-1:0];
          node_count_r <= node_count_r + NCW'(1);
          state_r      <= S_NEW2;
        end
        S_NEW2: begin
          node_count_r <= node_count_r + NCW'(1);
          col_count_r  <= col_count_r + CCW'(1);
          last_ext_r   <= CW'(new_end);
          out_strobe_r <= 1'b1;
          out_item_r   <= '{ST_OK, 10'(SW'(last_ext_r) + SW'(margin_r)),
                            10'(margin_r)};
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the block holds off only while working on an item
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // node count never passes the table depth
  assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r <= NCW'(MAX_NODES) && node_count_r != '0)
    else $error("node count out of range");

  // column count stays within its table
  assert property (@(posedge clk) disable iff (!rst_n)
    col_count_r <= CCW'(MAX_COLUMNS) && col_count_r != '0)
    else $error("column count out of range");

  // a result only comes while returning to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> state_r == S_IDLE)
    else $error("result while busy");

  // a parent write leads to an OK result strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WPAR |=> out_strobe_r && out_item_r.status == ST_OK)
    else $error("placement lost");

endmodule
